@@ src/rc_link_frame_check_failsafe_assert.svh @@
// Assertion macros, clocked on clk and disabled while rst_n is low.
`ifndef RC_LINK_FRAME_CHECK_FAILSAFE_ASSERT_SVH
`define RC_LINK_FRAME_CHECK_FAILSAFE_ASSERT_SVH

`ifndef SYNTHESIS

`define RCLFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define RCLFC_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`else

`define RCLFC_ASSERT(lbl, prop, msg)

`define RCLFC_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

@@ src/rclfc_pkg.sv @@
`default_nettype none

package rclfc_pkg;

    localparam logic [7:0] HEADER_VALUE_RST   = 8'd84;
    localparam logic [7:0] LOST_LIMIT_RST     = 8'd10;
    localparam logic [7:0] ARM_LOW_LIMIT_RST  = 8'd50;
    localparam logic [7:0] ARM_HIGH_LIMIT_RST = 8'd230;

    localparam int unsigned NUM_HELD = 5;

    localparam logic [7:0] CHK_MASK_THRUST = 8'b1100_0000;
    localparam logic [7:0] CHK_MASK_YAW    = 8'b0011_0000;
    localparam logic [7:0] CHK_MASK_PITCH  = 8'b0000_1100;
    localparam logic [7:0] CHK_MASK_ROLL   = 8'b0000_0011;

    localparam logic [7:0] MISSED_MAX = 8'hFF;

    typedef enum logic [1:0] {
        CFG_HEADER_VALUE   = 2'd0,
        CFG_LOST_LIMIT     = 2'd1,
        CFG_ARM_LOW_LIMIT  = 2'd2,
        CFG_ARM_HIGH_LIMIT = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] header_byte;
        logic [7:0] thrust_byte;
        logic [7:0] yaw_byte;
        logic [7:0] pitch_byte;
        logic [7:0] roll_byte;
        logic [7:0] switch_byte;
        logic [7:0] check_byte;
    } poll_t;

    typedef struct packed {
        logic       armed;
        logic       motor_stop;
        logic [7:0] thrust_out;
        logic [7:0] yaw_out;
        logic [7:0] pitch_out;
        logic [7:0] roll_out;
        logic       left_press;
        logic       header_fault;
        logic       check_fault;
        logic       link_lost;
    } result_t;

    typedef struct packed {
        cfg_reg_t   index;
        logic [7:0] data;
    } cfg_write_t;

    function automatic logic [7:0] frame_check(input logic [7:0] thrust, input logic [7:0] yaw,
                                               input logic [7:0] pitch, input logic [7:0] roll);
        frame_check = (thrust & CHK_MASK_THRUST) | (yaw & CHK_MASK_YAW)
                    | (pitch & CHK_MASK_PITCH) | (roll & CHK_MASK_ROLL);
    endfunction

endpackage

`default_nettype wire

@@ src/rclfc_if.sv @@
`default_nettype none

interface rclfc_poll_if import rclfc_pkg::*;;
    logic  valid;
    logic  ready;
    poll_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rclfc_result_if import rclfc_pkg::*;;
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rclfc_cfg_if import rclfc_pkg::*;;
    logic       valid;
    logic       ready;
    cfg_write_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/rc_link_frame_check_failsafe.sv @@
// Remote-control link frame check and failsafe.
// poll (sink): one item per link poll; mode 0 = no frame, 1 = seven-byte frame.
// result (source): one item per poll with arm status, motor stop, held stick
//   command, left switch press and the fault / link-lost flags.
// cfg (sink): register writes (header value, lost limit, arm limits), always
//   ready; write only while no poll is in flight.
// Path: an accepted poll goes into the input register, then its result into the
//   result register, which drives result valid and data. Throughput: one poll per
//   cycle while the receiver takes results, set by the single compute stage
//   between the two registers.
// The input register keeps accepting while a finished result waits; when the
//   receiver stalls, the result holds and at most one further poll is held in
//   the input register before poll ready drops.
// Reset: held bytes and missed-poll count clear, faults clear, left switch
//   reads released, disarmed, config registers take their defaults. The held
//   switch byte is zero after reset, so a first poll with no frame reports a left press.
`default_nettype none
`include "rc_link_frame_check_failsafe_assert.svh"

module rc_link_frame_check_failsafe
    import rclfc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    rclfc_poll_if.sink   poll,
    rclfc_result_if.source result,
    rclfc_cfg_if.sink    cfg
);

    logic [7:0] header_value_reg;
    logic [7:0] lost_limit_reg;
    logic [7:0] arm_low_limit_reg;
    logic [7:0] arm_high_limit_reg;

    logic       s1_valid_reg;
    poll_t      s1_data_reg;

    logic [7:0] held_reg [NUM_HELD];
    logic [7:0] held_next [NUM_HELD];
    logic [7:0] missed_reg;
    logic [7:0] missed_next;
    logic       header_ok_reg;
    logic       header_ok_next;
    logic       check_ok_reg;
    logic       check_ok_next;
    logic       prev_left_reg;
    logic       prev_left_next;
    logic       arm_reg;
    logic       arm_next;

    logic       out_valid_reg;
    result_t    out_data_reg;
    result_t    out_data_next;

    logic       advance;
    logic       press;
    logic       lost;
    logic       stop;
    logic       arm_gesture;

    assign advance      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign poll.ready   = !s1_valid_reg || advance;
    assign cfg.ready    = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_value_reg   <= HEADER_VALUE_RST;
            lost_limit_reg     <= LOST_LIMIT_RST;
            arm_low_limit_reg  <= ARM_LOW_LIMIT_RST;
            arm_high_limit_reg <= ARM_HIGH_LIMIT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                CFG_HEADER_VALUE:   header_value_reg   <= cfg.data.data;
                CFG_LOST_LIMIT:     lost_limit_reg     <= cfg.data.data;
                CFG_ARM_LOW_LIMIT:  arm_low_limit_reg  <= cfg.data.data;
                CFG_ARM_HIGH_LIMIT: arm_high_limit_reg <= cfg.data.data;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        held_next      = held_reg;
        missed_next    = missed_reg;
        header_ok_next = header_ok_reg;
        check_ok_next  = check_ok_reg;
        if (s1_data_reg.mode)
        begin
            missed_next  = '0;
            held_next[0] = s1_data_reg.thrust_byte;
            held_next[1] = s1_data_reg.yaw_byte;
            held_next[2] = s1_data_reg.pitch_byte;
            held_next[3] = s1_data_reg.roll_byte;
            held_next[4] = s1_data_reg.switch_byte;
            if (s1_data_reg.header_byte != header_value_reg)
            begin
                header_ok_next = 1'b0;
            end
            else if (s1_data_reg.check_byte != frame_check(s1_data_reg.thrust_byte,
                         s1_data_reg.yaw_byte, s1_data_reg.pitch_byte, s1_data_reg.roll_byte))
            begin
                check_ok_next = 1'b0;
            end
        end
        else if (missed_reg != MISSED_MAX)
        begin
            missed_next = missed_reg + 8'd1;
        end

        arm_gesture    = (held_next[0] <= arm_low_limit_reg)
                      && (held_next[1] >= arm_high_limit_reg);
        prev_left_next = held_next[4][0];
        press          = !held_next[4][0] && prev_left_reg;
        lost           = missed_next > lost_limit_reg;
        stop           = press || lost || !check_ok_next || !header_ok_next;
        arm_next       = !stop && (arm_reg || arm_gesture);

        out_data_next.armed        = arm_next;
        out_data_next.motor_stop   = stop;
        out_data_next.thrust_out   = held_next[0];
        out_data_next.yaw_out      = held_next[1];
        out_data_next.pitch_out    = held_next[2];
        out_data_next.roll_out     = held_next[3];
        out_data_next.left_press   = press;
        out_data_next.header_fault = !header_ok_next;
        out_data_next.check_fault  = !check_ok_next;
        out_data_next.link_lost    = lost;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_HELD; i++)
            begin
                held_reg[i] <= '0;
            end
            missed_reg    <= '0;
            header_ok_reg <= 1'b1;
            check_ok_reg  <= 1'b1;
            prev_left_reg <= 1'b1;
            arm_reg       <= 1'b0;
        end
        else
        begin
            if (poll.ready)
            begin
                s1_valid_reg <= poll.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                held_reg      <= held_next;
                missed_reg    <= missed_next;
                header_ok_reg <= header_ok_next;
                check_ok_reg  <= check_ok_next;
                prev_left_reg <= prev_left_next;
                arm_reg       <= arm_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll.valid && poll.ready)
        begin
            s1_data_reg <= poll.data;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    `RCLFC_ASSERT(a_stop_disarms, !out_valid_reg || !out_data_reg.motor_stop || !out_data_reg.armed, "armed while motors stopped")
    `RCLFC_ASSERT_NEXT(a_header_sticky, !header_ok_reg, !header_ok_reg, "header fault cleared")
    `RCLFC_ASSERT_NEXT(a_frame_clears_missed, advance && s1_data_reg.mode, missed_reg == 8'd0, "missed polls not cleared by frame")
    `RCLFC_ASSERT_NEXT(a_stalled_item_kept, s1_valid_reg && !advance, s1_valid_reg, "stalled poll dropped")
    `RCLFC_ASSERT(a_lost_matches, !out_valid_reg || (out_data_reg.link_lost == (missed_reg > lost_limit_reg)), "link lost flag out of step")

endmodule

`default_nettype wire
